// File: hdl/lfpp_pkg.sv
// Shared types for the length-framed packet parser.
package lfpp_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned COUNT_W = 2;

    // Parser phase: unused codes fall back to waiting for a start byte
    typedef enum logic [2:0] {
        PH_WAIT = 3'd0,
        PH_LEN  = 3'd1,
        PH_CMD  = 3'd2,
        PH_DATA = 3'd3,
        PH_CSUM = 3'd4
    } t_phase;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_LEN_ERR  = 2'd1,
        ST_CSUM_ERR = 2'd2
    } t_status;

    typedef struct packed {
        t_status              status;
        logic [BYTE_W-1:0]    command;
        logic [BYTE_W-1:0]    data_high;
        logic [BYTE_W-1:0]    data_low;
        logic [COUNT_W-1:0]   data_count;
    } t_result;

endpackage

// File: hdl/lfpp_in_stage.sv
// Input word register with valid flag.
module lfpp_in_stage (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_load,
    input  logic                        i_advance,
    input  logic [lfpp_pkg::BYTE_W-1:0] i_byte,
    output logic                        o_valid,
    output logic [lfpp_pkg::BYTE_W-1:0] o_byte
);

    logic                        r_valid;
    logic [lfpp_pkg::BYTE_W-1:0] r_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_advance) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_byte <= i_byte;
        end
    end

    assign o_valid = r_valid;
    assign o_byte  = r_byte;

endmodule

// File: hdl/lfpp_parse.sv
// Frame state machine: start byte, length, command, data, checksum.
module lfpp_parse (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [lfpp_pkg::BYTE_W-1:0] i_cfg_data,
    input  logic                        i_in_valid,
    input  logic                        i_advance,
    input  logic [lfpp_pkg::BYTE_W-1:0] i_byte,
    output logic                        o_res_hit,
    output lfpp_pkg::t_result           o_res
);

    logic [lfpp_pkg::BYTE_W-1:0]  r_start_byte;
    lfpp_pkg::t_phase             r_phase,     n_phase;
    logic [lfpp_pkg::BYTE_W-1:0]  r_remaining, n_remaining;
    logic [lfpp_pkg::BYTE_W-1:0]  r_sum,       n_sum;
    logic [lfpp_pkg::BYTE_W-1:0]  r_command,   n_command;
    logic [lfpp_pkg::BYTE_W-1:0]  r_data_high, n_data_high;
    logic [lfpp_pkg::BYTE_W-1:0]  r_data_low,  n_data_low;
    logic [lfpp_pkg::COUNT_W-1:0] r_data_seen, n_data_seen;

    logic                         hit;
    lfpp_pkg::t_result            res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_byte <= '0;
        end else if (i_cfg_we) begin
            r_start_byte <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= lfpp_pkg::PH_WAIT;
            r_remaining <= '0;
            r_sum       <= '0;
            r_command   <= '0;
            r_data_high <= '0;
            r_data_low  <= '0;
            r_data_seen <= '0;
        end else if (i_advance) begin
            r_phase     <= n_phase;
            r_remaining <= n_remaining;
            r_sum       <= n_sum;
            r_command   <= n_command;
            r_data_high <= n_data_high;
            r_data_low  <= n_data_low;
            r_data_seen <= n_data_seen;
        end
    end

    always_comb begin
        n_phase        = r_phase;
        n_remaining    = r_remaining;
        n_sum          = r_sum;
        n_command      = r_command;
        n_data_high    = r_data_high;
        n_data_low     = r_data_low;
        n_data_seen    = r_data_seen;
        hit            = 1'b0;
        res.status     = lfpp_pkg::ST_OK;
        res.command    = r_command;
        res.data_high  = r_data_high;
        res.data_low   = r_data_low;
        res.data_count = r_data_seen;

        case (r_phase)
            lfpp_pkg::PH_LEN: begin
                n_remaining = i_byte;
                n_sum       = r_sum + i_byte;
                n_phase     = lfpp_pkg::PH_CMD;
            end
            lfpp_pkg::PH_CMD: begin
                n_command   = i_byte;
                n_sum       = r_sum + i_byte;
                n_remaining = r_remaining - 8'd1;
                n_phase     = lfpp_pkg::PH_DATA;
            end
            lfpp_pkg::PH_DATA: begin
                if (r_remaining == 8'd2) begin
                    n_data_high = i_byte;
                    n_sum       = r_sum + i_byte;
                    n_remaining = 8'd1;
                    n_data_seen = r_data_seen + 2'd1;
                end else if (r_remaining == 8'd1) begin
                    n_data_low  = i_byte;
                    n_sum       = r_sum + i_byte;
                    n_remaining = '0;
                    n_data_seen = r_data_seen + 2'd1;
                    n_phase     = lfpp_pkg::PH_CSUM;
                end else if (r_remaining != 8'd0) begin
                    // bad length: drop this byte, report with data cleared
                    hit            = 1'b1;
                    res.status     = lfpp_pkg::ST_LEN_ERR;
                    res.data_high  = '0;
                    res.data_low   = '0;
                    res.data_count = '0;
                    n_data_high    = '0;
                    n_data_low     = '0;
                    n_data_seen    = '0;
                    n_phase        = lfpp_pkg::PH_WAIT;
                    n_remaining    = '0;
                    n_sum          = '0;
                end else begin
                    // command only: this byte is the checksum
                    hit         = 1'b1;
                    res.status  = (i_byte == r_sum) ? lfpp_pkg::ST_OK
                                                    : lfpp_pkg::ST_CSUM_ERR;
                    n_phase     = lfpp_pkg::PH_WAIT;
                    n_remaining = '0;
                    n_sum       = '0;
                end
            end
            lfpp_pkg::PH_CSUM: begin
                hit         = 1'b1;
                res.status  = (i_byte == r_sum) ? lfpp_pkg::ST_OK
                                                : lfpp_pkg::ST_CSUM_ERR;
                n_phase     = lfpp_pkg::PH_WAIT;
                n_remaining = '0;
                n_sum       = '0;
            end
            default: begin
                n_phase = lfpp_pkg::PH_WAIT;
                if (i_byte == r_start_byte) begin
                    n_phase     = lfpp_pkg::PH_LEN;
                    n_remaining = '0;
                    n_sum       = '0;
                    n_command   = '0;
                    n_data_high = '0;
                    n_data_low  = '0;
                    n_data_seen = '0;
                end
            end
        endcase
    end

    assign o_res_hit = i_in_valid & hit;
    assign o_res     = res;

endmodule

// File: hdl/lfpp_out_stage.sv
// Result register with valid flag toward the receiver.
module lfpp_out_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  lfpp_pkg::t_result i_res,
    input  logic              i_ready,
    output logic              o_valid,
    output logic              o_free,
    output lfpp_pkg::t_result o_res
);

    logic              r_valid;
    lfpp_pkg::t_result r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_free  = ~r_valid | i_ready;
    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

// File: hdl/length_framed_packet_parser.sv
// Top level of the length-framed packet parser.
//
// Input channel: one received word (i_rx_byte) per i_rx_valid/o_rx_ready
// handshake. Frames are start byte, length (1..3), command, up to two data
// words, then a checksum equal to the 8-bit wrapping sum of length, command
// and data. Words seen while hunting for the start byte are dropped.
// Output channel: one result per finished frame, good or bad, on
// o_res_valid/i_res_ready with status, command, data and data count.
// Config: i_cfg_we writes the start byte value at once; write only while
// idle.
// Flow: a word accepted into the input stage has its result (if any) loaded
// into the output stage as the word advances. Throughput: one word per cycle
// if not stalled, set by the single registered pass through the parser FSM.
// Stall: a held result blocks only words that would make a new result;
// other words keep flowing. Reset (i_rst_n low, synchronous) empties both
// stages, returns to start-byte hunt and sets the start byte to zero.
module length_framed_packet_parser (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [lfpp_pkg::BYTE_W-1:0] i_cfg_data,
    input  logic                        i_rx_valid,
    output logic                        o_rx_ready,
    input  logic [lfpp_pkg::BYTE_W-1:0] i_rx_byte,
    output logic                        o_res_valid,
    input  logic                        i_res_ready,
    output logic [1:0]                  o_status,
    output logic [lfpp_pkg::BYTE_W-1:0] o_command,
    output logic [lfpp_pkg::BYTE_W-1:0] o_data_high,
    output logic [lfpp_pkg::BYTE_W-1:0] o_data_low,
    output logic [lfpp_pkg::COUNT_W-1:0] o_data_count
);

    logic                        in_valid;
    logic [lfpp_pkg::BYTE_W-1:0] in_byte;
    logic                        res_hit;
    lfpp_pkg::t_result           res;
    logic                        out_free;
    logic                        advance;
    lfpp_pkg::t_result           out_res;

    // held word moves on unless it makes a result and the output is full
    assign advance    = in_valid & (~res_hit | out_free);
    assign o_rx_ready = ~in_valid | advance;

    lfpp_in_stage u_in (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_load    (i_rx_valid & o_rx_ready),
        .i_advance (advance),
        .i_byte    (i_rx_byte),
        .o_valid   (in_valid),
        .o_byte    (in_byte)
    );

    lfpp_parse u_parse (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_in_valid (in_valid),
        .i_advance  (advance),
        .i_byte     (in_byte),
        .o_res_hit  (res_hit),
        .o_res      (res)
    );

    lfpp_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (advance & res_hit),
        .i_res   (res),
        .i_ready (i_res_ready),
        .o_valid (o_res_valid),
        .o_free  (out_free),
        .o_res   (out_res)
    );

    assign o_status     = out_res.status;
    assign o_command    = out_res.command;
    assign o_data_high  = out_res.data_high;
    assign o_data_low   = out_res.data_low;
    assign o_data_count = out_res.data_count;

endmodule

// File: hdl/lfpp_checker.sv
// Port-level checks for the packet parser, bound to the top level.
module lfpp_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        o_res_valid,
    input logic                        i_res_ready,
    input logic [1:0]                  o_status,
    input logic [lfpp_pkg::BYTE_W-1:0] o_command,
    input logic [lfpp_pkg::BYTE_W-1:0] o_data_high,
    input logic [lfpp_pkg::BYTE_W-1:0] o_data_low,
    input logic [lfpp_pkg::COUNT_W-1:0] o_data_count
);

    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && !i_res_ready |=> o_res_valid && $stable(o_command))
        else $error("result dropped while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_res_valid)
        else $error("result valid right after reset");

    a_len_err_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_status == lfpp_pkg::ST_LEN_ERR |->
            o_data_count == 2'd0 && o_data_high == '0 && o_data_low == '0)
        else $error("length error carries data");

    a_high_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_data_count != 2'd2 |-> o_data_high == '0)
        else $error("high data byte set without two data bytes");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> o_status != 2'd3 && o_data_count != 2'd3)
        else $error("undefined status or count");

endmodule

bind length_framed_packet_parser lfpp_checker u_lfpp_checker (.*);

// File: sim/length_framed_packet_parser_tb.sv
// Testbench for the length-framed packet parser: directed frames, then random traffic.
`timescale 1ns / 1ps

module length_framed_packet_parser_tb;

    // Cycles with no handshake on either channel before the run is declared hung.
    // The longest legal quiet stretch is the receiver hold-off below.
    localparam int unsigned HANG_LIMIT   = 2000;
    localparam int unsigned HOLD_CYCLES  = 300;
    // Output is registered behind the input stage; these settle cycles cover it.
    localparam int unsigned SETTLE       = 4;
    localparam int unsigned WORDS_PER_PH = 120;
    localparam int unsigned NUM_PHASES   = 6;

    localparam lfpp_pkg::t_result NO_RESULT = '0;

    // One row of the directed table: a word, and optionally its result spelled out.
    typedef struct packed {
        logic [lfpp_pkg::BYTE_W-1:0] word;
        logic                        spelled;
        lfpp_pkg::t_result           res;
    } t_row;

    // Directed frames with the start byte at its reset value of zero.
    localparam int unsigned NUM_ROWS = 24;
    localparam t_row DIRECTED [NUM_ROWS] = '{
        '{8'h55, 1'b0, NO_RESULT},                          // noise while hunting
        '{8'h00, 1'b0, NO_RESULT},                          // command-only frame
        '{8'h01, 1'b0, NO_RESULT},
        '{8'hFF, 1'b0, NO_RESULT},
        '{8'h00, 1'b1, '{lfpp_pkg::ST_OK, 8'hFF, 8'h00, 8'h00, 2'd0}}, // 1 + FF wraps
        '{8'h00, 1'b0, NO_RESULT},                          // two data words
        '{8'h03, 1'b0, NO_RESULT},
        '{8'h80, 1'b0, NO_RESULT},
        '{8'hFF, 1'b0, NO_RESULT},
        '{8'h01, 1'b0, NO_RESULT},
        '{8'h83, 1'b0, NO_RESULT},
        '{8'h00, 1'b0, NO_RESULT},                          // one data word, equal
        '{8'h02, 1'b0, NO_RESULT},                          // to the start byte,
        '{8'h7F, 1'b0, NO_RESULT},                          // bad checksum
        '{8'h00, 1'b0, NO_RESULT},
        '{8'h55, 1'b1, '{lfpp_pkg::ST_CSUM_ERR, 8'h7F, 8'h00, 8'h00, 2'd1}},
        '{8'h00, 1'b0, NO_RESULT},                          // zero length
        '{8'h00, 1'b0, NO_RESULT},
        '{8'hAA, 1'b0, NO_RESULT},
        '{8'h33, 1'b1, '{lfpp_pkg::ST_LEN_ERR, 8'hAA, 8'h00, 8'h00, 2'd0}},
        '{8'h00, 1'b0, NO_RESULT},                          // largest length
        '{8'hFF, 1'b0, NO_RESULT},
        '{8'h01, 1'b0, NO_RESULT},
        '{8'h02, 1'b1, '{lfpp_pkg::ST_LEN_ERR, 8'h01, 8'h00, 8'h00, 2'd0}}
    };

    logic                          i_clk        = 1'b0;
    logic                          i_rst_n      = 1'b0;
    logic                          i_cfg_we     = 1'b0;
    logic [lfpp_pkg::BYTE_W-1:0]   i_cfg_data   = '0;
    logic                          i_rx_valid   = 1'b0;
    logic                          o_rx_ready;
    logic [lfpp_pkg::BYTE_W-1:0]   i_rx_byte    = '0;
    logic                          o_res_valid;
    logic                          i_res_ready  = 1'b0;
    logic [1:0]                    o_status;
    logic [lfpp_pkg::BYTE_W-1:0]   o_command;
    logic [lfpp_pkg::BYTE_W-1:0]   o_data_high;
    logic [lfpp_pkg::BYTE_W-1:0]   o_data_low;
    logic [lfpp_pkg::COUNT_W-1:0]  o_data_count;

    // Rides along with the word on offer: a result spelled out in the table.
    logic                          word_spelled = 1'b0;
    lfpp_pkg::t_result             word_spelled_res = '0;

    // Parser mirror: start byte and frame state as the block should hold them.
    logic [lfpp_pkg::BYTE_W-1:0]   start_val  = '0;
    lfpp_pkg::t_phase              frm_phase  = lfpp_pkg::PH_WAIT;
    logic [lfpp_pkg::BYTE_W-1:0]   frm_left   = '0;
    logic [lfpp_pkg::BYTE_W-1:0]   frm_sum    = '0;
    logic [lfpp_pkg::BYTE_W-1:0]   frm_cmd    = '0;
    logic [lfpp_pkg::BYTE_W-1:0]   frm_high   = '0;
    logic [lfpp_pkg::BYTE_W-1:0]   frm_low    = '0;
    logic [lfpp_pkg::COUNT_W-1:0]  frm_seen   = '0;

    lfpp_pkg::t_result    frames_due [$];   // parsed frames not yet seen on the output
    int unsigned          error_count = 0;
    int unsigned          words_sent  = 0;  // words offered in the current phase
    int unsigned          snd_idle_pct = 0;
    int unsigned          rcv_idle_pct = 0;
    int unsigned          hold_reqs    = 0;
    int unsigned          quiet_run    = 0;

    length_framed_packet_parser i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .i_rx_valid   (i_rx_valid),
        .o_rx_ready   (o_rx_ready),
        .i_rx_byte    (i_rx_byte),
        .o_res_valid  (o_res_valid),
        .i_res_ready  (i_res_ready),
        .o_status     (o_status),
        .o_command    (o_command),
        .o_data_high  (o_data_high),
        .o_data_low   (o_data_low),
        .o_data_count (o_data_count)
    );

    always #5 i_clk = ~i_clk;

    // Advance the frame state by one received word; returns 1 when a frame closes.
    function automatic bit parse_word(input logic [lfpp_pkg::BYTE_W-1:0] w,
                                      output lfpp_pkg::t_result r);
        bit                closes;
        lfpp_pkg::t_status st;
        closes = 1'b0;
        st     = lfpp_pkg::ST_OK;
        r      = NO_RESULT;
        case (frm_phase)
            lfpp_pkg::PH_LEN: begin
                frm_left  = w;
                frm_sum   = frm_sum + w;
                frm_phase = lfpp_pkg::PH_CMD;
            end
            lfpp_pkg::PH_CMD: begin
                frm_cmd   = w;
                frm_sum   = frm_sum + w;
                frm_left  = frm_left - 8'd1;   // length 0 wraps to FF
                frm_phase = lfpp_pkg::PH_DATA;
            end
            lfpp_pkg::PH_DATA: begin
                if (frm_left == 8'd2) begin
                    frm_high = w;
                    frm_sum  = frm_sum + w;
                    frm_left = 8'd1;
                    frm_seen = frm_seen + 2'd1;
                end else if (frm_left == 8'd1) begin
                    frm_low   = w;
                    frm_sum   = frm_sum + w;
                    frm_left  = 8'd0;
                    frm_seen  = frm_seen + 2'd1;
                    frm_phase = lfpp_pkg::PH_CSUM;
                end else if (frm_left != 8'd0) begin
                    // bad length: this word is dropped, data reads as empty
                    frm_high = '0;
                    frm_low  = '0;
                    frm_seen = '0;
                    st       = lfpp_pkg::ST_LEN_ERR;
                    closes   = 1'b1;
                end else begin
                    // command only: this word is already the checksum
                    st     = (w == frm_sum) ? lfpp_pkg::ST_OK : lfpp_pkg::ST_CSUM_ERR;
                    closes = 1'b1;
                end
            end
            lfpp_pkg::PH_CSUM: begin
                st     = (w == frm_sum) ? lfpp_pkg::ST_OK : lfpp_pkg::ST_CSUM_ERR;
                closes = 1'b1;
            end
            default: begin
                frm_phase = lfpp_pkg::PH_WAIT;
                if (w == start_val) begin
                    frm_phase = lfpp_pkg::PH_LEN;
                    frm_left  = '0;
                    frm_sum   = '0;
                    frm_cmd   = '0;
                    frm_high  = '0;
                    frm_low   = '0;
                    frm_seen  = '0;
                end
            end
        endcase
        if (closes) begin
            r.status     = st;
            r.command    = frm_cmd;
            r.data_high  = frm_high;
            r.data_low   = frm_low;
            r.data_count = frm_seen;
            frm_phase    = lfpp_pkg::PH_WAIT;
            frm_left     = '0;
            frm_sum      = '0;
        end
        return closes;
    endfunction

    task automatic flag_error(input string msg);
        error_count++;
        $display("%0d ns: %s", $time, msg);
    endtask

    // Accepted words feed the mirror; accepted results are matched against the
    // oldest frame due. Both are sampled at the edge, before any update lands.
    always @(posedge i_clk) begin : watch
        lfpp_pkg::t_result pred;
        lfpp_pkg::t_result due;
        if (i_rst_n) begin
            if (i_rx_valid && o_rx_ready) begin
                if (parse_word(i_rx_byte, pred))
                    frames_due.push_back(word_spelled ? word_spelled_res : pred);
            end
            if (o_res_valid && i_res_ready) begin
                if (frames_due.size() == 0) begin
                    flag_error($sformatf("result with nothing due: st=%0d cmd=%02h",
                                         o_status, o_command));
                end else begin
                    due = frames_due.pop_front();
                    if (o_status !== due.status || o_command !== due.command ||
                        o_data_high !== due.data_high || o_data_low !== due.data_low ||
                        o_data_count !== due.data_count)
                        flag_error({
                            $sformatf("mismatch got st=%0d cmd=%02h hi=%02h lo=%02h n=%0d",
                                      o_status, o_command, o_data_high, o_data_low,
                                      o_data_count),
                            $sformatf(", want st=%0d cmd=%02h hi=%02h lo=%02h n=%0d",
                                      due.status, due.command, due.data_high,
                                      due.data_low, due.data_count)});
                end
            end
        end
    end

    // Receiver: random back-pressure, plus a long hold-off counted here on request.
    always @(posedge i_clk) begin : sink
        int unsigned hold_seen;
        int unsigned hold_left;
        if (hold_seen != hold_reqs) begin
            hold_seen = hold_reqs;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left != 0) begin
            hold_left--;
            i_res_ready <= 1'b0;
        end else begin
            i_res_ready <= ($urandom_range(99) >= rcv_idle_pct);
        end
    end

    // Hang detector: counts cycles where neither channel moves anything.
    always @(posedge i_clk) begin
        if ((i_rx_valid && o_rx_ready) || (o_res_valid && i_res_ready))
            quiet_run <= 0;
        else
            quiet_run <= quiet_run + 1;
        if (quiet_run >= HANG_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // Offer one word and return at the edge that takes it. Entered at an edge;
    // valid only drops when the sender decides to idle before the word.
    task automatic send_word(input logic [lfpp_pkg::BYTE_W-1:0] w, input logic spelled,
                             input lfpp_pkg::t_result res);
        if (snd_idle_pct != 0 && $urandom_range(99) < snd_idle_pct) begin
            i_rx_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < snd_idle_pct);
        end
        i_rx_valid       <= 1'b1;
        i_rx_byte        <= w;
        word_spelled     <= spelled;
        word_spelled_res <= res;
        do @(posedge i_clk); while (!(i_rx_valid && o_rx_ready));
    endtask

    // Stop offering, let every due frame come out, then let the pipe settle.
    task automatic drain;
        i_rx_valid <= 1'b0;
        while (frames_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_start(input logic [lfpp_pkg::BYTE_W-1:0] v);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        start_val   = v;   // nothing is in flight, so the mirror can change now
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    // One random frame. Mostly well formed with random content; some carry a bad
    // checksum, a bad length, or are just the start byte followed by junk that
    // throws the framing off until the next frame closes.
    task automatic send_frame(input logic [lfpp_pkg::BYTE_W-1:0] sb);
        logic [lfpp_pkg::BYTE_W-1:0] len;
        logic [lfpp_pkg::BYTE_W-1:0] cmd;
        logic [lfpp_pkg::BYTE_W-1:0] d0;
        logic [lfpp_pkg::BYTE_W-1:0] d1;
        logic [lfpp_pkg::BYTE_W-1:0] sum;
        logic [lfpp_pkg::BYTE_W-1:0] w;
        int unsigned                 kind;
        int unsigned                 n;
        // line noise ahead of the frame, never the start byte itself
        n = ($urandom_range(9) < 2) ? $urandom_range(1, 3) : 0;
        repeat (n) begin
            w = 8'($urandom_range(255));
            if (w == sb)
                w = ~w;
            send_word(w, 1'b0, NO_RESULT);
        end
        words_sent += n;
        kind = $urandom_range(99);
        cmd  = 8'($urandom_range(255));
        d0   = 8'($urandom_range(255));
        d1   = 8'($urandom_range(255));
        send_word(sb, 1'b0, NO_RESULT);
        if (kind < 85) begin
            len = 8'($urandom_range(1, 3));
            sum = len + cmd;
            send_word(len, 1'b0, NO_RESULT);
            send_word(cmd, 1'b0, NO_RESULT);
            if (len == 8'd3) begin
                send_word(d0, 1'b0, NO_RESULT);
                sum = sum + d0;
            end
            if (len >= 8'd2) begin
                send_word(d1, 1'b0, NO_RESULT);
                sum = sum + d1;
            end
            if (kind >= 75)
                sum = sum ^ 8'($urandom_range(1, 255));
            send_word(sum, 1'b0, NO_RESULT);
            words_sent += len + 3;
        end else if (kind < 93) begin
            len = $urandom_range(1) ? 8'd0 : 8'($urandom_range(4, 255));
            send_word(len, 1'b0, NO_RESULT);
            send_word(cmd, 1'b0, NO_RESULT);
            send_word(d0, 1'b0, NO_RESULT);
            words_sent += 4;
        end else begin
            n = $urandom_range(1, 5);
            repeat (n) send_word(8'($urandom_range(255)), 1'b0, NO_RESULT);
            words_sent += n + 1;
        end
    endtask

    initial begin
        logic [lfpp_pkg::BYTE_W-1:0] sb;
        bit                          paused;
        bit                          held;
        paused = 1'b0;
        held   = 1'b0;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed frames under the first idle mix; start byte still zero.
        snd_idle_pct = 34;
        rcv_idle_pct = 50;
        for (int i = 0; i < NUM_ROWS; i++)
            send_word(DIRECTED[i].word, DIRECTED[i].spelled, DIRECTED[i].res);

        // Random phases: each starts from a drained block with a new start byte.
        // Idle mix: sender light/receiver heavy, then swapped, then none at all.
        for (int p = 0; p < NUM_PHASES; p++) begin
            drain();
            case (p)
                0:       sb = 8'hFF;
                2:       sb = 8'h00;
                default: sb = 8'($urandom_range(255));
            endcase
            write_start(sb);
            if (p < 2) begin
                snd_idle_pct = 34;
                rcv_idle_pct = 50;
            end else if (p < 4) begin
                snd_idle_pct = 50;
                rcv_idle_pct = 34;
            end else begin
                snd_idle_pct = 0;
                rcv_idle_pct = 0;
            end
            words_sent = 0;
            while (words_sent < WORDS_PER_PH) begin
                send_frame(sb);
                // sender waits mid-phase until the output has caught up
                if (p == 2 && !paused && words_sent >= 60) begin
                    drain();
                    paused = 1'b1;
                end
                // receiver stops while words keep coming, so the block backs up
                if (p == 4 && !held && words_sent >= 40) begin
                    hold_reqs++;
                    held = 1'b1;
                end
            end
        end

        drain();
        if (error_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
